// ----- src/plob_pkg.sv -----
// ----------------------------------------------------------------------------
// plob_pkg: shared types and constants of the price level order book.
// Request and result payloads, action codes and the cell control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package plob_pkg;
    localparam int LEVELS = 64;
    localparam int CW = $clog2(LEVELS + 1);

    typedef enum logic [1:0] {
        KIND_SNAP = 2'd0,
        KIND_UPD = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_UPDATE = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_IGNORE = 3'd3,
        ACT_EVICT = 3'd4,
        ACT_DROP = 3'd5,
        ACT_CLEAR = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS = 2'd1,
        OP_DEL = 2'd2,
        OP_SET = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_FIND = 2'd1,
        ST_APPLY = 2'd2,
        ST_OUT = 2'd3
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        side;
        logic [30:0] price;
        logic [47:0] volume;
        logic        end_of_message;
    } req_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [30:0] best_bid_price;
        logic [47:0] best_bid_volume;
        logic [30:0] best_ask_price;
        logic [47:0] best_ask_volume;
        logic        top_valid;
        logic [6:0]  bid_levels;
        logic [6:0]  ask_levels;
        logic        message_done;
    } rsp_t;

    typedef struct packed {
        op_t         op;
        logic        side;
        logic [30:0] price;
        logic [47:0] volume;
    } ctl_t;

    typedef struct packed {
        logic        ahead;
        logic        equal;
    } flag_t;
endpackage
`default_nettype wire

// ----- src/plob_cell.sv -----
// ----------------------------------------------------------------------------
// plob_cell: one stored level of one side.
// Compares its price with the request and shifts, overwrites or holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module plob_cell (
    input  wire logic           aclk,
    input  wire plob_pkg::ctl_t ctl,
    input  wire logic           side,
    input  wire logic           sel,
    input  wire logic           shift_in,
    input  wire logic [30:0]    prev_price,
    input  wire logic [47:0]    prev_volume,
    input  wire logic           shift_out,
    input  wire logic [30:0]    next_price,
    input  wire logic [47:0]    next_volume,
    output plob_pkg::flag_t     flag,
    output logic [30:0]         price,
    output logic [47:0]         volume
);
    logic [30:0] price_reg;
    logic [47:0] volume_reg;

    always_comb begin
        flag.ahead = side ? (price_reg < ctl.price) : (price_reg > ctl.price);
        flag.equal = price_reg == ctl.price;
    end

    always_ff @(posedge aclk) begin
        if (ctl.side == side) begin
            case (ctl.op)
                plob_pkg::OP_INS: begin
                    if (sel) begin
                        price_reg <= ctl.price;
                        volume_reg <= ctl.volume;
                    end else if (shift_in) begin
                        price_reg <= prev_price;
                        volume_reg <= prev_volume;
                    end
                end
                plob_pkg::OP_DEL: begin
                    if (shift_out) begin
                        price_reg <= next_price;
                        volume_reg <= next_volume;
                    end
                end
                plob_pkg::OP_SET: begin
                    if (sel) begin
                        volume_reg <= ctl.volume;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign price = price_reg;
    assign volume = volume_reg;
endmodule
`default_nettype wire

// ----- src/plob_side.sv -----
// ----------------------------------------------------------------------------
// plob_side: the sorted chain of cells for one side of the book.
// Gives the insertion position and whether the price is present.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module plob_side (
    input  wire logic                      aclk,
    input  wire plob_pkg::ctl_t            ctl,
    input  wire logic                      side,
    input  wire logic [plob_pkg::CW-1:0]   count,
    input  wire logic [plob_pkg::CW-1:0]   pos,
    output logic [plob_pkg::CW-1:0]        find_pos,
    output logic                           found,
    output logic [30:0]                    top_price,
    output logic [47:0]                    top_volume
);
    localparam int N = plob_pkg::LEVELS;
    localparam int CW = plob_pkg::CW;

    logic [30:0] pr [N];
    logic [47:0] vo [N];
    plob_pkg::flag_t fl [N];
    logic [N-1:0] ahd;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic [30:0] pp;
            logic [47:0] pv;
            logic [30:0] np;
            logic [47:0] nv;
            if (g == 0) begin : g_first
                assign pp = '0;
                assign pv = '0;
            end else begin : g_mid
                assign pp = pr[g-1];
                assign pv = vo[g-1];
            end
            if (g == N - 1) begin : g_last
                assign np = '0;
                assign nv = '0;
            end else begin : g_body
                assign np = pr[g+1];
                assign nv = vo[g+1];
            end
            plob_cell u_cell (
                .aclk(aclk),
                .ctl(ctl),
                .side(side),
                .sel(pos == CW'(g)),
                .shift_in(CW'(g) > pos),
                .prev_price(pp),
                .prev_volume(pv),
                .shift_out(CW'(g) >= pos),
                .next_price(np),
                .next_volume(nv),
                .flag(fl[g]),
                .price(pr[g]),
                .volume(vo[g])
            );
            assign ahd[g] = fl[g].ahead && (CW'(g) < count);
        end
    endgenerate

    always_comb begin
        find_pos = CW'($countones(ahd));
        found = 1'b0;
        for (int k = 0; k < N; k++) begin
            if (CW'(k) == find_pos && CW'(k) < count && fl[k].equal) begin
                found = 1'b1;
            end
        end
    end

    assign top_price = pr[0];
    assign top_volume = vo[0];
endmodule
`default_nettype wire

// ----- src/price_level_order_book_unit.sv -----
// ----------------------------------------------------------------------------
// price_level_order_book_unit: bid and ask level tables with top of book.
// Each accepted request steps through the find, apply and report states;
// the result is offered in report and held there until m_ready takes it.
// One request is held at a time; a new one is accepted only when idle.
// Reset clears state and level counts; cell contents are unused until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module price_level_order_book_unit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire plob_pkg::req_t  s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output plob_pkg::rsp_t       m_data
);
    localparam int CW = plob_pkg::CW;
    localparam int N = plob_pkg::LEVELS;

    plob_pkg::state_t state_reg, state_next;
    plob_pkg::req_t req_reg;
    logic [CW-1:0] bid_count_reg, ask_count_reg, pos_reg;
    logic found_reg;
    plob_pkg::action_t act_reg;
    plob_pkg::ctl_t ctl;
    logic [CW-1:0] bpos, apos;
    logic bfound, afound;
    logic [30:0] bp, ap;
    logic [47:0] bv, av;
    logic [CW-1:0] cnt;
    logic [CW-1:0] cnt_next;
    plob_pkg::action_t act_next;
    plob_pkg::op_t op;
    logic tv;

    plob_side u_bid (.aclk(aclk), .ctl(ctl), .side(1'b0), .count(bid_count_reg),
        .pos(pos_reg), .find_pos(bpos), .found(bfound), .top_price(bp), .top_volume(bv));
    plob_side u_ask (.aclk(aclk), .ctl(ctl), .side(1'b1), .count(ask_count_reg),
        .pos(pos_reg), .find_pos(apos), .found(afound), .top_price(ap), .top_volume(av));

    assign cnt = req_reg.side ? ask_count_reg : bid_count_reg;

    always_comb begin
        op = plob_pkg::OP_HOLD;
        act_next = plob_pkg::ACT_IGNORE;
        cnt_next = cnt;
        if (found_reg) begin
            if (req_reg.kind == plob_pkg::KIND_UPD && req_reg.volume == '0) begin
                op = plob_pkg::OP_DEL;
                act_next = plob_pkg::ACT_DELETE;
                cnt_next = cnt - 1'b1;
            end else begin
                op = plob_pkg::OP_SET;
                act_next = plob_pkg::ACT_UPDATE;
            end
        end else if (req_reg.kind == plob_pkg::KIND_UPD && req_reg.volume == '0) begin
            act_next = plob_pkg::ACT_IGNORE;
        end else if (cnt >= CW'(N)) begin
            if (pos_reg >= CW'(N)) begin
                act_next = plob_pkg::ACT_DROP;
            end else begin
                op = plob_pkg::OP_INS;
                act_next = plob_pkg::ACT_EVICT;
            end
        end else begin
            op = plob_pkg::OP_INS;
            act_next = plob_pkg::ACT_INSERT;
            cnt_next = cnt + 1'b1;
        end
    end

    always_comb begin
        ctl.side = req_reg.side;
        ctl.price = req_reg.price;
        ctl.volume = req_reg.volume;
        ctl.op = (state_reg == plob_pkg::ST_APPLY &&
                  (req_reg.kind == plob_pkg::KIND_SNAP || req_reg.kind == plob_pkg::KIND_UPD))
                 ? op : plob_pkg::OP_HOLD;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            plob_pkg::ST_IDLE: if (s_valid) state_next = plob_pkg::ST_FIND;
            plob_pkg::ST_FIND: state_next = plob_pkg::ST_APPLY;
            plob_pkg::ST_APPLY: state_next = plob_pkg::ST_OUT;
            plob_pkg::ST_OUT: if (m_ready) state_next = plob_pkg::ST_IDLE;
            default: state_next = plob_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= plob_pkg::ST_IDLE;
            bid_count_reg <= '0;
            ask_count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == plob_pkg::ST_APPLY) begin
                case (req_reg.kind)
                    plob_pkg::KIND_SNAP, plob_pkg::KIND_UPD: begin
                        if (req_reg.side) ask_count_reg <= cnt_next;
                        else bid_count_reg <= cnt_next;
                    end
                    plob_pkg::KIND_CLEAR: begin
                        bid_count_reg <= '0;
                        ask_count_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == plob_pkg::ST_IDLE && s_valid) req_reg <= s_data;
        if (state_reg == plob_pkg::ST_FIND) begin
            pos_reg <= req_reg.side ? apos : bpos;
            found_reg <= req_reg.side ? afound : bfound;
        end
        if (state_reg == plob_pkg::ST_APPLY) begin
            case (req_reg.kind)
                plob_pkg::KIND_SNAP, plob_pkg::KIND_UPD: act_reg <= act_next;
                plob_pkg::KIND_CLEAR: act_reg <= plob_pkg::ACT_CLEAR;
                default: act_reg <= plob_pkg::ACT_IGNORE;
            endcase
        end
    end

    always_comb begin
        s_ready = state_reg == plob_pkg::ST_IDLE;
        m_valid = state_reg == plob_pkg::ST_OUT;
        tv = bid_count_reg != '0 && ask_count_reg != '0;
        m_data.action = act_reg;
        m_data.best_bid_price = tv ? bp : '0;
        m_data.best_bid_volume = tv ? bv : '0;
        m_data.best_ask_price = tv ? ap : '0;
        m_data.best_ask_volume = tv ? av : '0;
        m_data.top_valid = tv;
        m_data.bid_levels = 7'(bid_count_reg);
        m_data.ask_levels = 7'(ask_count_reg);
        m_data.message_done = req_reg.end_of_message;
    end
endmodule
`default_nettype wire

// ----- tb/sv/price_level_order_book_unit_tb.sv -----
// ----------------------------------------------------------------------------
// price_level_order_book_unit_tb: self-checking bench for the order book unit.
// Drives snapshot, update, clear and KIND_NONE requests with random bursts and stalls,
// predicts the bid and ask level tables and compares every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module price_level_order_book_unit_tb;

    class book_scoreboard;
        logic [30:0] bid_px[$];
        logic [47:0] bid_vol[$];
        logic [30:0] ask_px[$];
        logic [47:0] ask_vol[$];
        plob_pkg::rsp_t pending[$];
        int          mismatches;

        function bit better(logic s, logic [30:0] a, logic [30:0] b);
            return s ? (a < b) : (a > b);
        endfunction

        function plob_pkg::action_t apply_level(logic s, logic [30:0] px,
                                                logic [47:0] vol, bit is_upd);
            logic [30:0] p[$];
            logic [47:0] v[$];
            int          i;
            plob_pkg::action_t act;
            p = s ? ask_px : bid_px;
            v = s ? ask_vol : bid_vol;
            i = 0;
            while (i < p.size() && better(s, p[i], px)) i++;
            if (i < p.size() && p[i] == px) begin
                if (is_upd && vol == 0) begin
                    p.delete(i);
                    v.delete(i);
                    act = plob_pkg::ACT_DELETE;
                end else begin
                    v[i] = vol;
                    act = plob_pkg::ACT_UPDATE;
                end
            end else if (is_upd && vol == 0) begin
                act = plob_pkg::ACT_IGNORE;
            end else if (p.size() >= plob_pkg::LEVELS && i >= plob_pkg::LEVELS) begin
                act = plob_pkg::ACT_DROP;
            end else begin
                act = plob_pkg::ACT_INSERT;
                if (p.size() >= plob_pkg::LEVELS) begin
                    void'(p.pop_back());
                    void'(v.pop_back());
                    act = plob_pkg::ACT_EVICT;
                end
                p.insert(i, px);
                v.insert(i, vol);
            end
            if (s) begin
                ask_px = p;
                ask_vol = v;
            end else begin
                bid_px = p;
                bid_vol = v;
            end
            return act;
        endfunction

        function void note_request(plob_pkg::req_t r);
            plob_pkg::rsp_t e;
            e = '0;
            case (plob_pkg::kind_t'(r.kind))
                plob_pkg::KIND_SNAP: e.action = apply_level(r.side, r.price, r.volume, 0);
                plob_pkg::KIND_UPD: e.action = apply_level(r.side, r.price, r.volume, 1);
                plob_pkg::KIND_CLEAR: begin
                    bid_px.delete();
                    bid_vol.delete();
                    ask_px.delete();
                    ask_vol.delete();
                    e.action = plob_pkg::ACT_CLEAR;
                end
                default: e.action = plob_pkg::ACT_IGNORE;
            endcase
            if (bid_px.size() > 0 && ask_px.size() > 0) begin
                e.top_valid = 1'b1;
                e.best_bid_price = bid_px[0];
                e.best_bid_volume = bid_vol[0];
                e.best_ask_price = ask_px[0];
                e.best_ask_volume = ask_vol[0];
            end
            e.bid_levels = 7'(bid_px.size());
            e.ask_levels = 7'(ask_px.size());
            e.message_done = r.end_of_message;
            pending.push_back(e);
        endfunction

        function void check_result(plob_pkg::rsp_t got);
            plob_pkg::rsp_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch: expected %p", e);
                    $display("          actual   %p", got);
                end
            end
        endfunction
    endclass

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    plob_pkg::req_t s_data;
    logic  m_valid;
    logic  m_ready;
    plob_pkg::rsp_t m_data;

    book_scoreboard book;
    bit          long_hold;
    int          idle_cycles = 0;
    logic [30:0] hot_px[8];

    price_level_order_book_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) book.check_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold = 0;
            end
            n = $urandom_range(0, 3);
            if (n == 0) m_ready <= 1'b0;
            else if (n == 1) m_ready <= ($urandom_range(0, 1) == 1);
            else m_ready <= 1'b1;
        end
    end

    task automatic send(plob_pkg::req_t r);
        s_valid <= 1'b1;
        s_data <= r;
        do @(posedge aclk); while (!s_ready);
        book.note_request(r);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_level(plob_pkg::kind_t k, logic s, logic [30:0] px,
                              logic [47:0] vol, logic eom);
        plob_pkg::req_t r;
        r.kind = k;
        r.side = s;
        r.price = px;
        r.volume = vol;
        r.end_of_message = eom;
        send(r);
    endtask

    task automatic drain();
        while (book.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic logic [30:0] pick_price();
        case ($urandom_range(0, 4))
            0: return 31'($urandom);
            1: return hot_px[$urandom_range(0, 7)];
            default: return 31'(1000 + $urandom_range(0, 150));
        endcase
    endfunction

    function automatic logic [47:0] pick_volume();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 48'({$urandom, $urandom});
            default: return 48'($urandom_range(1, 5000));
        endcase
    endfunction

    initial begin
        int    i;
        int    sent;
        int    burst;
        plob_pkg::req_t r;
        book = new();
        s_valid = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        long_hold = 0;
        for (i = 0; i < 8; i++) hot_px[i] = 31'($urandom);
        hot_px[0] = '0;
        hot_px[1] = '1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_level(plob_pkg::KIND_SNAP, 1'b0, 31'd100, 48'd5, 1'b0);
        send_level(plob_pkg::KIND_SNAP, 1'b1, 31'd110, '1, 1'b1);
        send_level(plob_pkg::KIND_SNAP, 1'b0, '1, '0, 1'b0);
        send_level(plob_pkg::KIND_SNAP, 1'b1, '0, 48'd7, 1'b1);
        send_level(plob_pkg::KIND_UPD, 1'b0, 31'd100, 48'd9, 1'b0);
        send_level(plob_pkg::KIND_UPD, 1'b0, 31'd55, '0, 1'b0);
        send_level(plob_pkg::KIND_UPD, 1'b1, '0, '0, 1'b1);
        send_level(plob_pkg::KIND_UPD, 1'b0, '1, '0, 1'b1);
        send_level(plob_pkg::KIND_NONE, 1'b1, '1, '1, 1'b1);
        send_level(plob_pkg::KIND_CLEAR, 1'b1, '0, '0, 1'b0);
        send_level(plob_pkg::KIND_UPD, 1'b1, 31'd3, '1, 1'b0);
        for (i = 0; i < 64; i++)
            send_level(plob_pkg::KIND_SNAP, 1'b0, 31'(500 + i), 48'(i), i == 63);
        send_level(plob_pkg::KIND_SNAP, 1'b0, 31'd10, 48'd1, 1'b0);
        send_level(plob_pkg::KIND_SNAP, 1'b0, 31'd900, 48'd2, 1'b1);
        send_level(plob_pkg::KIND_UPD, 1'b0, 31'd902, 48'd3, 1'b1);
        drain();

        long_hold = 1;
        for (i = 0; i < 12; i++)
            send_level(plob_pkg::KIND_SNAP, 1'b1, 31'(20 + i), 48'(i), 1'b0);
        drain();

        sent = 0;
        while (sent < 1260) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                r.kind = ($urandom_range(0, 99) < 2) ? plob_pkg::KIND_CLEAR :
                         ($urandom_range(0, 99) < 1) ? plob_pkg::KIND_NONE :
                         ($urandom_range(0, 2) == 0) ? plob_pkg::KIND_SNAP :
                         plob_pkg::KIND_UPD;
                r.side = 1'($urandom_range(0, 1));
                r.price = pick_price();
                r.volume = pick_volume();
                r.end_of_message = 1'($urandom_range(0, 1));
                send(r);
                sent++;
            end
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        drain();
        if (book.mismatches == 0 && book.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
